// ===== rtl/dda_line_rasterizer_top_assert.svh =====
// Assertion macros for the line rasterizer; clk and arst_n are taken from the enclosing scope.
`ifndef DDA_LINE_RASTERIZER_TOP_ASSERT_SVH
`define DDA_LINE_RASTERIZER_TOP_ASSERT_SVH

// same-cycle implication
`define DDA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dda check failed");

// next-cycle implication
`define DDA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dda sequence check failed");

`endif

// ===== rtl/dda_pkg.sv =====
package dda_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;

	localparam int ACC_W   = COORD_BITS + 2 + FRAC_BITS;
	localparam int STEP_W  = FRAC_BITS + 2;
	localparam int QUOT_W  = FRAC_BITS + 1;
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int CNT_W   = $clog2(QUOT_W);
	localparam int S_TDATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVX,
		ST_DIVY,
		ST_FIN
	} dda_state_t;

	typedef struct packed {
		logic                  start;
		logic [COORD_BITS-1:0] numer;
		logic [COORD_BITS-1:0] denom;
	} dda_div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [QUOT_W-1:0] quot;
	} dda_div_rsp_t;

	// round half away from zero, keep the low coordinate bits
	function automatic logic [COORD_BITS-1:0] round_out(input logic signed [ACC_W-1:0] acc);
		logic [ACC_W-1:0]      mag;
		logic [ACC_W:0]        sum;
		logic [COORD_BITS-1:0] m;
		mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
		sum = {1'b0, mag} + ((ACC_W + 1)'(1) << (FRAC_BITS - 1));
		m   = sum[FRAC_BITS +: COORD_BITS];
		return acc[ACC_W-1] ? COORD_BITS'(-m) : m;
	endfunction

	function automatic logic signed [STEP_W-1:0] apply_sign(input logic neg,
			input logic [QUOT_W-1:0] q);
		logic signed [STEP_W-1:0] qe;
		qe = STEP_W'(q);
		return neg ? STEP_W'(-qe) : qe;
	endfunction

endpackage

// ===== rtl/dda_div.sv =====
module dda_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dda_pkg::dda_div_req_t req,
	output dda_pkg::dda_div_rsp_t rsp
);
	import dda_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [COORD_BITS-1:0] rem_q;
	logic [COORD_BITS-1:0] denom_q;
	logic [QUOT_W-1:0]     num_q;
	logic [QUOT_W-1:0]     quot_q;

	logic [COORD_BITS:0]   trial;
	logic [COORD_BITS:0]   diff;
	logic                  ge;
	logic                  last;

	// one restoring step per cycle; remainder stays below the divisor
	assign trial = {rem_q, num_q[QUOT_W-1]};
	assign diff  = trial - {1'b0, denom_q};
	assign ge    = trial >= {1'b0, denom_q};
	assign last  = busy_q && (cnt_q == CNT_W'(QUOT_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// the numerator is mag << FRAC_BITS; the quotient fits QUOT_W bits, so start from mag >> 1
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q   <= req.numer >> 1;
			num_q   <= QUOT_W'(req.numer[0]) << FRAC_BITS;
			denom_q <= req.denom;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
			num_q  <= num_q << 1;
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ===== rtl/dda_line_rasterizer_top.sv =====
// Channel | Dir | tdata (low bit up)                    | tuser       | tlast
// s_      | in  | x_start, y_start, x_stop, y_stop      | op          | -
// m_      | out | point_x, point_y                      | point_valid | last_point
//
// A step word is accepted when the block is idle and the output slot is
// free or being emptied, and its point is in the output register on the next cycle.
// For a start word of a line with length, the two increments go one after the other through
// one shared restoring divider; a start word of a line with no length skips the divider.
// Reset leaves no line active and the output empty. A stalled output holds the input off.
module dda_line_rasterizer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [dda_pkg::S_TDATA_W-1:0]  s_tdata,  // x_start, y_start, x_stop, y_stop
	input  logic                           s_tuser,  // op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [dda_pkg::M_TDATA_W-1:0]  m_tdata,  // point_x, point_y
	output logic                           m_tuser,  // point_valid
	output logic                           m_tlast
);
	import dda_pkg::*;

	dda_state_t state_q, state_d;
	dda_div_req_t div_req;
	dda_div_rsp_t div_rsp;

	logic signed [COORD_BITS-1:0] x_start, y_start, x_stop, y_stop;
	logic signed [DIFF_W-1:0]     dx, dy;
	logic [COORD_BITS-1:0]        magx, magy, steps_in;
	logic                         acc_in, out_free, step_last;
	logic signed [ACC_W-1:0]      nx_acc_x, nx_acc_y;

	logic signed [ACC_W-1:0]      acc_x_q, acc_y_q;
	logic signed [STEP_W-1:0]     step_x_q, step_y_q;
	logic [COORD_BITS-1:0]        steps_left_q;
	logic                         line_active_q;
	logic signed [COORD_BITS-1:0] xs_q, ys_q;
	logic                         negx_q, negy_q;
	logic [COORD_BITS-1:0]        magy_q, steps_q;
	logic                         m_tvalid_q, pvalid_q, plast_q;
	logic [COORD_BITS-1:0]        pt_x_q, pt_y_q;

	assign x_start = s_tdata[0*COORD_BITS +: COORD_BITS];
	assign y_start = s_tdata[1*COORD_BITS +: COORD_BITS];
	assign x_stop  = s_tdata[2*COORD_BITS +: COORD_BITS];
	assign y_stop  = s_tdata[3*COORD_BITS +: COORD_BITS];

	assign dx       = DIFF_W'(x_stop) - DIFF_W'(x_start);
	assign dy       = DIFF_W'(y_stop) - DIFF_W'(y_start);
	assign magx     = dx[DIFF_W-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
	assign magy     = dy[DIFF_W-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
	assign steps_in = (magx >= magy) ? magx : magy;

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign acc_in    = s_tvalid && s_tready;
	assign nx_acc_x  = acc_x_q + ACC_W'(step_x_q);
	assign nx_acc_y  = acc_y_q + ACC_W'(step_y_q);
	assign step_last = steps_left_q == COORD_BITS'(1);

	dda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		state_d       = state_q;
		div_req.start = 1'b0;
		div_req.numer = magx;
		div_req.denom = steps_in;
		case (state_q)
			ST_IDLE: begin
				if (acc_in && s_tuser == OP_START) begin
					if (steps_in != '0) begin
						div_req.start = 1'b1;
						state_d       = ST_DIVX;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_DIVX: begin
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					div_req.numer = magy_q;
					div_req.denom = steps_q;
					state_d       = ST_DIVY;
				end
			end
			ST_DIVY: begin
				if (div_rsp.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q       <= '0;
			acc_y_q       <= '0;
			step_x_q      <= '0;
			step_y_q      <= '0;
			steps_left_q  <= '0;
			line_active_q <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (state_q == ST_DIVX && div_rsp.done) begin
				step_x_q <= apply_sign(negx_q, div_rsp.quot);
			end
			if (state_q == ST_DIVY && div_rsp.done) begin
				step_y_q <= apply_sign(negy_q, div_rsp.quot);
			end
			if (acc_in && s_tuser == OP_STEP) begin
				m_tvalid_q <= 1'b1;
				if (line_active_q) begin
					acc_x_q      <= nx_acc_x;
					acc_y_q      <= nx_acc_y;
					steps_left_q <= steps_left_q - COORD_BITS'(1);
					if (step_last) begin
						line_active_q <= 1'b0;
					end
				end
			end else if (state_q == ST_FIN && out_free) begin
				m_tvalid_q    <= 1'b1;
				acc_x_q       <= ACC_W'(xs_q) <<< FRAC_BITS;
				acc_y_q       <= ACC_W'(ys_q) <<< FRAC_BITS;
				steps_left_q  <= steps_q;
				line_active_q <= steps_q != '0;
				if (steps_q == '0) begin
					step_x_q <= '0;
					step_y_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && s_tuser == OP_START) begin
			xs_q    <= x_start;
			ys_q    <= y_start;
			negx_q  <= dx[DIFF_W-1];
			negy_q  <= dy[DIFF_W-1];
			magy_q  <= magy;
			steps_q <= steps_in;
		end
		if (acc_in && s_tuser == OP_STEP) begin
			if (line_active_q) begin
				pt_x_q   <= round_out(nx_acc_x);
				pt_y_q   <= round_out(nx_acc_y);
				pvalid_q <= 1'b1;
				plast_q  <= step_last;
			end else begin
				// no line: emit an empty word
				pt_x_q   <= '0;
				pt_y_q   <= '0;
				pvalid_q <= 1'b0;
				plast_q  <= 1'b0;
			end
		end else if (state_q == ST_FIN && out_free) begin
			pt_x_q   <= xs_q;
			pt_y_q   <= ys_q;
			pvalid_q <= 1'b1;
			plast_q  <= steps_q == '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'({pt_y_q, pt_x_q});
	assign m_tuser  = pvalid_q;
	assign m_tlast  = plast_q;

`include "dda_line_rasterizer_top_assert.svh"

	`DDA_ASSERT_IMP(a_busy_not_ready, state_q != ST_IDLE, !s_tready)
	`DDA_ASSERT_IMP(a_active_has_steps, line_active_q, steps_left_q != '0)
	`DDA_ASSERT_IMP(a_div_state, div_rsp.busy || div_rsp.done, state_q == ST_DIVX || state_q == ST_DIVY)
	`DDA_ASSERT_NEXT(a_divy_to_fin, state_q == ST_DIVY && div_rsp.done, state_q == ST_FIN)
	`DDA_ASSERT_IMP(a_empty_not_last, m_tvalid && !m_tuser, !m_tlast)

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	import dda_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int WORD_TARGET = 600;
	localparam int LONG_HOLD   = 300;
	localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
	localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  valid;
		logic                  last;
	} point_t;

	class dda_point_tracker;
		logic signed [ACC_W-1:0]  acc_x;
		logic signed [ACC_W-1:0]  acc_y;
		logic signed [STEP_W-1:0] inc_x;
		logic signed [STEP_W-1:0] inc_y;
		logic [COORD_BITS-1:0]    steps_left;
		bit                       drawing;
		point_t                   due_points[$];
		int                       errors;

		function new();
			acc_x = '0;
			acc_y = '0;
			inc_x = '0;
			inc_y = '0;
			steps_left = '0;
			drawing = 1'b0;
			errors = 0;
		endfunction

		// round half away from zero, keep the low coordinate bits
		function logic [COORD_BITS-1:0] to_pixel(logic signed [ACC_W-1:0] acc);
			longint a;
			longint m;
			a = acc;
			m = ((a < 0 ? -a : a) + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
			if (a < 0)
				m = -m;
			return COORD_BITS'(m);
		endfunction

		// delta / span in fixed point, truncated toward zero
		function longint increment(longint delta, longint span);
			longint q;
			q = ((delta < 0 ? -delta : delta) << FRAC_BITS) / span;
			return delta < 0 ? -q : q;
		endfunction

		function void note_word(logic op, coord_t xs, coord_t ys, coord_t xe, coord_t ye);
			point_t p;
			longint dx;
			longint dy;
			longint span;
			p = '0;
			if (op == OP_START) begin
				dx = longint'(xe) - longint'(xs);
				dy = longint'(ye) - longint'(ys);
				span = (dx < 0 ? -dx : dx);
				if ((dy < 0 ? -dy : dy) > span)
					span = (dy < 0 ? -dy : dy);
				acc_x = ACC_W'(longint'(xs) << FRAC_BITS);
				acc_y = ACC_W'(longint'(ys) << FRAC_BITS);
				if (span == 0) begin
					inc_x = '0;
					inc_y = '0;
					steps_left = '0;
					drawing = 1'b0;
					p.last = 1'b1;
				end else begin
					inc_x = STEP_W'(increment(dx, span));
					inc_y = STEP_W'(increment(dy, span));
					steps_left = COORD_BITS'(span);
					drawing = 1'b1;
				end
				p.valid = 1'b1;
				p.x = to_pixel(acc_x);
				p.y = to_pixel(acc_y);
			end else if (drawing) begin
				acc_x = acc_x + inc_x;
				acc_y = acc_y + inc_y;
				steps_left = steps_left - 1'b1;
				if (steps_left == 0) begin
					drawing = 1'b0;
					p.last = 1'b1;
				end
				p.valid = 1'b1;
				p.x = to_pixel(acc_x);
				p.y = to_pixel(acc_y);
			end
			due_points.push_back(p);
		endfunction

		function void check_point(point_t got);
			point_t want;
			if (due_points.size() == 0) begin
				$display("%0t: point with nothing due: x=%0d y=%0d valid=%0b last=%0b", $time,
					$signed(got.x), $signed(got.y), got.valid, got.last);
				errors++;
				return;
			end
			want = due_points.pop_front();
			if (got.x !== want.x) begin
				$display("%0t: point_x expected %0d got %0d", $time, $signed(want.x),
					$signed(got.x));
				errors++;
			end
			if (got.y !== want.y) begin
				$display("%0t: point_y expected %0d got %0d", $time, $signed(want.y),
					$signed(got.y));
				errors++;
			end
			if (got.valid !== want.valid) begin
				$display("%0t: point_valid expected %0b got %0b", $time, want.valid, got.valid);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last_point expected %0b got %0b", $time, want.last, got.last);
				errors++;
			end
		endfunction

		function int pending();
			return due_points.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	dda_point_tracker tracker = new();
	int words_sent = 0;
	int quiet_cycles = 0;

	dda_line_rasterizer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAIL dda_line_rasterizer_top");
			$finish;
		end
	end

	function automatic coord_t clamp_coord(longint v);
		if (v > COORD_MAX)
			return coord_t'(COORD_MAX);
		if (v < COORD_MIN)
			return coord_t'(COORD_MIN);
		return coord_t'(v);
	endfunction

	function automatic int line_span(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
		int dx;
		int dy;
		dx = int'(xe) - int'(xs);
		dy = int'(ye) - int'(ys);
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		return dx > dy ? dx : dy;
	endfunction

	task automatic send_word(input logic op, input coord_t xs, input coord_t ys,
			input coord_t xe, input coord_t ye);
		int gap;
		gap = (words_sent % 64 < 16) ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {ye, xe, ys, xs};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.note_word(op, xs, ys, xe, ye);
		words_sent++;
	endtask

	task automatic draw_line(input coord_t xs, input coord_t ys, input coord_t xe,
			input coord_t ye, input int n);
		send_word(OP_START, xs, ys, xe, ye);
		// step words carry junk coordinates; the block must ignore them
		repeat (n)
			send_word(OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom));
	endtask

	task automatic drain_points();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// output side: random stalls, one long hold to back the block up
	initial begin
		int got_count;
		int gap;
		point_t got;
		got_count = 0;
		wait (arst_n);
		forever begin
			if (got_count == 200)
				gap = LONG_HOLD;
			else
				gap = (got_count % 64 < 16) ? 0 : $urandom_range(0, 5);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			got.x     = m_tdata[COORD_BITS-1:0];
			got.y     = m_tdata[2*COORD_BITS-1:COORD_BITS];
			got.valid = m_tuser;
			got.last  = m_tlast;
			tracker.check_point(got);
			got_count++;
		end
	end

	initial begin
		int r;
		int n;
		int span;
		bit drained;
		coord_t xs;
		coord_t ys;
		coord_t xe;
		coord_t ye;
		drained = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// step with no line, zero-length line, then a step on the idle block
		send_word(OP_STEP, '0, '0, '0, '0);
		draw_line(5, -7, 5, -7, 1);
		// longest diagonal, dropped by the next start
		draw_line(-2048, -2048, 2047, 2047, 2);
		// run to the end at the coordinate edges, one step past it
		draw_line(2047, -2048, 2040, -2045, 8);
		// exact halves round away from zero, then a vertical line with negative y steps
		draw_line(0, 0, 2, -1, 2);
		draw_line(10, 20, 10, 16, 4);

		while (words_sent < WORD_TARGET) begin
			if (!drained && words_sent > WORD_TARGET / 2) begin
				drain_points();
				drained = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 12) begin
				send_word(1'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), coord_t'($urandom));
			end else begin
				xs = coord_t'($urandom);
				ys = coord_t'($urandom);
				if (r < 24) begin
					xe = coord_t'($urandom);
					ye = coord_t'($urandom);
				end else begin
					xe = clamp_coord(longint'(xs) + int'($urandom_range(0, 48)) - 24);
					ye = clamp_coord(longint'(ys) + int'($urandom_range(0, 48)) - 24);
				end
				span = line_span(xs, ys, xe, ye);
				if (span > 40)
					n = $urandom_range(0, 40);
				else if ($urandom_range(0, 9) < 7)
					n = span + $urandom_range(0, 1);
				else
					n = $urandom_range(0, span);
				draw_line(xs, ys, xe, ye, n);
			end
		end

		drain_points();
		repeat (40) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("PASS dda_line_rasterizer_top");
		else
			$display("FAIL dda_line_rasterizer_top");
		$finish;
	end

endmodule

// ===== dda_line_rasterizer_top.f =====
+incdir+rtl
rtl/dda_pkg.sv
rtl/dda_div.sv
rtl/dda_line_rasterizer_top.sv
sim/tb_top.sv
